FILE: sv/csah_pkg.sv
// Shared types and constants for the cache slice address hash unit.
package csah_pkg;

  // Stream payload layout of the input beat (tdata, lowest bit first).
  localparam int AddrW      = 64;
  localparam int TableIdxW  = 9;
  localparam int MaskW      = 64;
  localparam int SeqValW    = 6;
  localparam int AddrLsb    = 0;
  localparam int TableIdxLsb = AddrLsb + AddrW;
  localparam int MaskLsb    = TableIdxLsb + TableIdxW;
  localparam int SeqValLsb  = MaskLsb + MaskW;
  localparam int InDataW    = ((SeqValLsb + SeqValW + 7) / 8) * 8;

  // Result beat layout.
  localparam int SliceW     = 16;
  localparam int OutDataW   = 16;

  // Cache line size is fixed at 64 bytes.
  localparam int LineShift  = 6;

  // Configuration port.
  localparam int ApbAddrW   = 4;
  localparam int ApbDataW   = 32;
  localparam int AddrBitsW  = 6;
  localparam int MaskCountW = 5;
  localparam int SeqLogW    = 4;

  localparam logic [1:0] REG_ADDRESS_BITS = 2'd0;
  localparam logic [1:0] REG_MASK_COUNT   = 2'd1;
  localparam logic [1:0] REG_SEQ_LOG2     = 2'd2;

  localparam logic [AddrBitsW-1:0]  AddrBitsReset  = 6'd39;
  localparam logic [MaskCountW-1:0] MaskCountReset = 5'd9;
  localparam logic [SeqLogW-1:0]    SeqLogReset    = 4'd0;

  // Operation carried in tuser of the input beat; the unused code acts as a lookup.
  typedef enum logic [1:0] {
    OP_LOOKUP  = 2'd0,
    OP_MASK_WR = 2'd1,
    OP_SEQ_WR  = 2'd2
  } op_e;

  // Status carried in tuser of the result beat.
  typedef enum logic [1:0] {
    ST_SLICE_OK     = 2'd0,
    ST_OUT_OF_RANGE = 2'd1,
    ST_WRITE_DONE   = 2'd2
  } status_e;

endpackage

FILE: sv/cache_slice_address_hash_unit.sv
// Top level: XOR-mask slice hash with an optional base-sequence table.
//
//  channel | direction | handshake                   | payload
//  s_axis  | in        | tvalid/tready               | tuser operation, tdata fields
//  m_axis  | out       | tvalid/tready               | tuser status, tdata slice
//  apb     | in        | psel/penable/pwrite, pready | paddr/pwdata, prdata
//
// One beat is accepted per cycle while s_axis_tready is high; its result passes stage 1, then stage 2.
// The first stage computes the mask parities and the table position, the second
// reads or writes the sequence memory through its single port.
// Mask words are written at the acceptance edge, so the next beat already uses them.
// Reset clears the valid bits and presets configuration; mask and sequence stores stay unset.
// A stalled result holds its stage; the input keeps flowing while the middle stage is free.
module cache_slice_address_hash_unit #(
  parameter int MAX_MASKS = 16,
  parameter int SEQ_DEPTH = 512
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input stream.
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // tdata: address[63:0], table_index[72:64], mask_value[136:73],
  // sequence_value[142:137], zero pad[143]
  input  logic [csah_pkg::InDataW-1:0]   s_axis_tdata,
  // tuser: operation[1:0]
  input  logic [1:0]                     s_axis_tuser,
  // Result stream.
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // tdata: slice[15:0]
  output logic [csah_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: status[1:0]
  output logic [1:0]                     m_axis_tuser,
  // Configuration port.
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [csah_pkg::ApbAddrW-1:0]  paddr,
  input  logic [csah_pkg::ApbDataW-1:0]  pwdata,
  output logic [csah_pkg::ApbDataW-1:0]  prdata,
  output logic                           pready
);
  import csah_pkg::*;

  localparam int SeqAw     = $clog2(SEQ_DEPTH);
  localparam int SeqLenMax = $clog2(SEQ_DEPTH + 1) - 1;

  // Configuration registers.
  logic [AddrBitsW-1:0]  address_bits_q;
  logic [MaskCountW-1:0] mask_count_q;
  logic [SeqLogW-1:0]    seq_log2_q;
  logic                  cfg_wr;

  // Input field views.
  logic [AddrW-1:0]     in_address;
  logic [TableIdxW-1:0] in_table_index;
  logic [MaskW-1:0]     in_mask_value;
  logic [SeqValW-1:0]   in_seq_value;
  logic                 s_accept;

  // Mask store, read in parallel by the hash.
  logic [MaskW-1:0] mask_q [MAX_MASKS];

  // Stage 0 results.
  logic [MAX_MASKS-1:0] raw_hash;
  logic [AddrW-1:0]     raw_wide;
  logic [SeqAw-1:0]     len_mask;
  logic [SeqAw-1:0]     line_idx;
  logic [SeqAw-1:0]     seq_pos;
  logic [31:0]          idx_wide;
  logic                 out_of_range;
  logic [6:0]           top_bit;
  status_e              st0;
  logic [MAX_MASKS-1:0] raw0;
  logic                 use_seq0;
  logic                 seq_we0;
  logic [SeqAw-1:0]     addr0;

  // Stage 1 registers.
  logic                 v1_q;
  status_e              st1_q;
  logic [MAX_MASKS-1:0] raw1_q;
  logic                 use_seq1_q;
  logic                 seq_we1_q;
  logic [SeqAw-1:0]     addr1_q;
  logic [SeqValW-1:0]   wdata1_q;

  // Stage 2 (result) registers.
  logic                 v2_q;
  status_e              st2_q;
  logic [MAX_MASKS-1:0] raw2_q;
  logic                 use_seq2_q;
  logic [SeqValW-1:0]   rdata2_q;

  // Sequence memory.
  logic [SeqValW-1:0] seq_mem [SEQ_DEPTH];

  logic en2;
  logic move12;

  assign in_address     = s_axis_tdata[AddrLsb +: AddrW];
  assign in_table_index = s_axis_tdata[TableIdxLsb +: TableIdxW];
  assign in_mask_value  = s_axis_tdata[MaskLsb +: MaskW];
  assign in_seq_value   = s_axis_tdata[SeqValLsb +: SeqValW];

  // Pipeline flow control.
  assign en2           = !v2_q || m_axis_tready;
  assign move12        = v1_q && en2;
  assign s_axis_tready = !v1_q || en2;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  // Configuration writes and reads.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      address_bits_q <= AddrBitsReset;
      mask_count_q   <= MaskCountReset;
      seq_log2_q     <= SeqLogReset;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ADDRESS_BITS: address_bits_q <= pwdata[AddrBitsW-1:0];
        REG_MASK_COUNT:   mask_count_q   <= pwdata[MaskCountW-1:0];
        REG_SEQ_LOG2:     seq_log2_q     <= pwdata[SeqLogW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ADDRESS_BITS: prdata = ApbDataW'(address_bits_q);
      REG_MASK_COUNT:   prdata = ApbDataW'(mask_count_q);
      REG_SEQ_LOG2:     prdata = ApbDataW'(seq_log2_q);
      default:          prdata = '0;
    endcase
  end

  // Mask words are taken at the acceptance edge.
  always_ff @(posedge clk_i) begin
    if (s_accept && s_axis_tuser == OP_MASK_WR) begin
      for (int i = 0; i < MAX_MASKS; i++) begin
        if (32'(in_table_index) == i) begin
          mask_q[i] <= in_mask_value;
        end
      end
    end
  end

  // Hash: one parity per enabled mask, then the sequence table position.
  always_comb begin
    for (int b = 0; b < MAX_MASKS; b++) begin
      raw_hash[b] = (b < 32'(mask_count_q)) && (^(mask_q[b] & in_address));
    end
    raw_wide = AddrW'(raw_hash);
    for (int i = 0; i < SeqAw; i++) begin
      len_mask[i] = (i < 32'(seq_log2_q)) && (i < SeqLenMax);
    end
    line_idx = in_address[LineShift +: SeqAw];
    seq_pos  = (line_idx ^ raw_wide[SeqAw-1:0]) & len_mask;
    top_bit      = 7'(address_bits_q) + 7'd1;
    out_of_range = |(in_address & ({AddrW{1'b1}} << top_bit));
    idx_wide     = 32'(in_table_index);
  end

  // Decode of the operation into what the later stages need.
  always_comb begin
    st0      = ST_SLICE_OK;
    raw0     = '0;
    use_seq0 = 1'b0;
    seq_we0  = 1'b0;
    addr0    = seq_pos;
    case (s_axis_tuser)
      OP_MASK_WR: begin
        st0 = ST_WRITE_DONE;
      end
      OP_SEQ_WR: begin
        st0     = ST_WRITE_DONE;
        seq_we0 = idx_wide < SEQ_DEPTH;
        addr0   = idx_wide[SeqAw-1:0];
      end
      default: begin
        if (out_of_range) begin
          st0 = ST_OUT_OF_RANGE;
        end else begin
          raw0     = raw_hash;
          use_seq0 = seq_log2_q != '0;
        end
      end
    endcase
  end

  // Stage valid bits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (en2) begin
        v2_q <= v1_q;
      end
    end
  end

  // Stage 1 payload.
  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      st1_q      <= st0;
      raw1_q     <= raw0;
      use_seq1_q <= use_seq0;
      seq_we1_q  <= seq_we0;
      addr1_q    <= addr0;
      wdata1_q   <= in_seq_value;
    end
  end

  // Sequence memory: one access per beat, in beat order.
  always_ff @(posedge clk_i) begin
    if (move12 && seq_we1_q) begin
      seq_mem[addr1_q] <= wdata1_q;
    end
    if (move12) begin
      rdata2_q <= seq_mem[addr1_q];
    end
  end

  // Stage 2 payload.
  always_ff @(posedge clk_i) begin
    if (move12) begin
      st2_q      <= st1_q;
      raw2_q     <= raw1_q;
      use_seq2_q <= use_seq1_q;
    end
  end

  // Result beat.
  assign m_axis_tvalid = v2_q;
  assign m_axis_tuser  = st2_q;
  assign m_axis_tdata  = use_seq2_q ? OutDataW'(rdata2_q) : OutDataW'(raw2_q);

endmodule

FILE: sv/csah_checker.sv
// Port-level checker for the cache slice address hash unit and its bind.
module csah_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [csah_pkg::OutDataW-1:0]  m_axis_tdata,
  input logic [1:0]                     m_axis_tuser
);
  import csah_pkg::*;

  // No result is shown while reset is applied.
  assert property (@(posedge clk_i) !rst_ni |-> !m_axis_tvalid)
    else $error("result valid during reset");

  // A stalled result beat holds its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // With the result stage empty the input side always has room.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result stage");

  // Out-of-range lookups and table writes carry a zero slice.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser == ST_OUT_OF_RANGE || m_axis_tuser == ST_WRITE_DONE)
      |-> m_axis_tdata == '0)
    else $error("nonzero slice on non-lookup status");

endmodule

bind cache_slice_address_hash_unit csah_checker u_csah_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
